/* src/ncps_pkg.sv */
// Shared constants for the normalized cross-power spectrum core.
package ncps_pkg;

    // Default sample width of each input part
    localparam int SAMPLE_WIDTH_DEF = 16;
    // The larger normalized magnitude lies in [2^NORM_BIT, 2^(NORM_BIT+1))
    localparam int NORM_BIT = 29;
    localparam int X_W      = NORM_BIT + 1;
    // Sum of two squares of normalized values
    localparam int SQ_W     = 2 * X_W + 1;
    // Integer square root of the sum
    localparam int ROOT_W   = (SQ_W + 1) / 2;
    // Output quotient, Q1.15 magnitude whose integer bit serves as the overflow bit
    localparam int OUT_W    = 16;
    localparam int Q_W      = OUT_W;
    localparam int FRAC_W   = OUT_W - 1;
    localparam logic [OUT_W-1:0] Q15_ONE = OUT_W'((1 << FRAC_W) - 1);
    // Rounded numerator x * Q15_ONE + floor(M / 2)
    localparam int NUM_W    = X_W + FRAC_W + 1;

endpackage

/* src/ncps_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module ncps_isqrt import ncps_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_sq,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int RW = 2 * ROOT_W;

    logic [RW-1:0]     r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    logic [SIDE_W-1:0] r_side [0:ROOT_W-1];
    logic              r_vld  [0:ROOT_W-1];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam int K = ROOT_W - 1 - s;
        logic [RW-1:0]     rem_in;
        logic [RW-1:0]     trial;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic              take;

        if (s == 0) begin : g_first
            assign rem_in  = RW'(i_sq);
            assign root_in = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        // Test (2*root + 2^K) * 2^K against the remainder
        assign trial = (RW'(root_in) << (K + 1)) | (RW'(1) << (2 * K));
        assign take  = (rem_in >= trial);

        // Advance data one bit of the root
        always_ff @(posedge i_clk) begin
            r_rem[s]  <= take ? (rem_in - trial) : rem_in;
            r_root[s] <= take ? (root_in | (ROOT_W'(1) << K)) : root_in;
            r_side[s] <= side_in;
        end

        // Advance valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

/* src/ncps_qdiv.sv */
// Pipelined restoring divider, two numerators over one shared divisor.
module ncps_qdiv import ncps_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num_re,
    input  logic [NUM_W-1:0]  i_num_im,
    input  logic [ROOT_W-1:0] i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_q_re,
    output logic [Q_W-1:0]    o_q_im,
    output logic [SIDE_W-1:0] o_side
);
    logic [NUM_W-1:0]  r_rem_re [0:Q_W-1];
    logic [NUM_W-1:0]  r_rem_im [0:Q_W-1];
    logic [Q_W-1:0]    r_q_re   [0:Q_W-1];
    logic [Q_W-1:0]    r_q_im   [0:Q_W-1];
    logic [ROOT_W-1:0] r_den    [0:Q_W-1];
    logic [SIDE_W-1:0] r_side   [0:Q_W-1];
    logic              r_vld    [0:Q_W-1];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int K = Q_W - 1 - s;
        logic [NUM_W-1:0]  re_in;
        logic [NUM_W-1:0]  im_in;
        logic [Q_W-1:0]    qre_in;
        logic [Q_W-1:0]    qim_in;
        logic [ROOT_W-1:0] den_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [NUM_W-1:0]  dsh;
        logic              take_re;
        logic              take_im;

        if (s == 0) begin : g_first
            assign re_in   = i_num_re;
            assign im_in   = i_num_im;
            assign qre_in  = '0;
            assign qim_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign re_in   = r_rem_re[s-1];
            assign im_in   = r_rem_im[s-1];
            assign qre_in  = r_q_re[s-1];
            assign qim_in  = r_q_im[s-1];
            assign den_in  = r_den[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        // Compare both remainders against the shifted divisor
        assign dsh     = NUM_W'(den_in) << K;
        assign take_re = (re_in >= dsh);
        assign take_im = (im_in >= dsh);

        // Advance one quotient bit
        always_ff @(posedge i_clk) begin
            r_rem_re[s] <= take_re ? (re_in - dsh) : re_in;
            r_rem_im[s] <= take_im ? (im_in - dsh) : im_in;
            r_q_re[s]   <= take_re ? (qre_in | (Q_W'(1) << K)) : qre_in;
            r_q_im[s]   <= take_im ? (qim_in | (Q_W'(1) << K)) : qim_in;
            r_den[s]    <= den_in;
            r_side[s]   <= side_in;
        end

        // Advance valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_q_re  = r_q_re[Q_W-1];
    assign o_q_im  = r_q_im[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

/* src/normalized_cross_power_spectrum_core.sv */
// Normalized cross-power spectrum core: one bin, A * conj(B) / |A * conj(B)|, in Q1.15.
// The core takes one bin pair in every cycle and never raises o_busy. Each transaction
// passes 56 register stages up to o_valid: seven stages of magnitude, product, sum,
// leading one, normalize, square and sum of squares, 31 stages of the square root (one
// root bit each), one numerator stage, 16 stages of the divider (one quotient bit each)
// and the output register.
// Results cannot be held off, so o_valid and the result ports are valid for one cycle
// only. A zero product gives zero outputs with o_zero_magnitude set.
module normalized_cross_power_spectrum_core import ncps_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic signed [SAMPLE_WIDTH-1:0] i_a_real,
    input  logic signed [SAMPLE_WIDTH-1:0] i_a_imag,
    input  logic signed [SAMPLE_WIDTH-1:0] i_b_real,
    input  logic signed [SAMPLE_WIDTH-1:0] i_b_imag,
    output logic                           o_valid,
    output logic signed [OUT_W-1:0]        o_norm_real,
    output logic signed [OUT_W-1:0]        o_norm_imag,
    output logic                           o_zero_magnitude
);
    localparam int MW  = SAMPLE_WIDTH;
    localparam int PW  = 2 * SAMPLE_WIDTH;
    localparam int SW  = PW + 1;
    localparam int XW  = (SW > X_W) ? SW : X_W;
    localparam int LW  = $clog2(XW);
    localparam int SQW = 2 * X_W;
    localparam int SIDE_SQRT = 2 * X_W + 3;
    localparam int SIDE_DIV  = 3;

    // Stage 1: magnitudes and signs
    logic [MW-1:0] r_m_ar, r_m_ai, r_m_br, r_m_bi;
    logic          r_s_ar, r_s_ai, r_s_br, r_s_bi;
    // Stage 2: partial products
    logic [PW-1:0] r_p_arbr, r_p_aibi, r_p_aibr, r_p_arbi;
    logic          r_n_arbr, r_n_aibi, r_n_aibr, r_n_arbi;
    // Stage 3: real and imaginary parts of the product
    logic [SW-1:0] r_tr3, r_ti3;
    logic          r_ntr3, r_nti3;
    // Stage 4: leading one of the larger part
    logic [XW-1:0] r_tr4, r_ti4;
    logic [LW-1:0] r_lead4;
    logic          r_ntr4, r_nti4, r_zero4;
    // Stage 5: normalized parts
    logic [X_W-1:0] r_xr5, r_xi5;
    logic           r_ntr5, r_nti5, r_zero5;
    // Stage 6: squares
    logic [SQW-1:0] r_sqr6, r_sqi6;
    logic [X_W-1:0] r_xr6, r_xi6;
    logic           r_ntr6, r_nti6, r_zero6;
    // Stage 7: sum of squares
    logic [SQ_W-1:0] r_sum7;
    logic [X_W-1:0]  r_xr7, r_xi7;
    logic            r_ntr7, r_nti7, r_zero7;
    // Stage after root: numerators
    logic [NUM_W-1:0]  r_num_re, r_num_im;
    logic [ROOT_W-1:0] r_den;
    logic [SIDE_DIV-1:0] r_side8;
    logic              r_vld_num;
    // Output
    logic [OUT_W-1:0] r_out_re, r_out_im;
    logic             r_out_zero;
    // Valid chain for the front stages
    logic [6:0] r_vld;

    logic [MW-1:0] n_m_ar, n_m_ai, n_m_br, n_m_bi;
    logic [SW-1:0] n_tr, n_ti;
    logic          n_ntr, n_nti;
    logic [SW-1:0] n_mx;
    logic [LW-1:0] n_lead;
    logic [XW-1:0] n_xr, n_xi;
    logic          accept;

    logic                 sq_valid;
    logic [ROOT_W-1:0]    sq_root;
    logic [SIDE_SQRT-1:0] sq_side;
    logic [X_W-1:0]       sq_xr, sq_xi;
    logic                 dv_valid;
    logic [Q_W-1:0]       dv_q_re, dv_q_im;
    logic [SIDE_DIV-1:0]  dv_side;
    logic [Q_W-1:0]       sat_re, sat_im;

    assign o_busy = 1'b0;
    assign accept = i_start;

    // Take magnitudes of the four parts
    assign n_m_ar = i_a_real[MW-1] ? (MW'(0) - MW'(i_a_real)) : MW'(i_a_real);
    assign n_m_ai = i_a_imag[MW-1] ? (MW'(0) - MW'(i_a_imag)) : MW'(i_a_imag);
    assign n_m_br = i_b_real[MW-1] ? (MW'(0) - MW'(i_b_real)) : MW'(i_b_real);
    assign n_m_bi = i_b_imag[MW-1] ? (MW'(0) - MW'(i_b_imag)) : MW'(i_b_imag);

    always_ff @(posedge i_clk) begin
        r_m_ar <= n_m_ar;
        r_m_ai <= n_m_ai;
        r_m_br <= n_m_br;
        r_m_bi <= n_m_bi;
        r_s_ar <= i_a_real[MW-1];
        r_s_ai <= i_a_imag[MW-1];
        r_s_br <= i_b_real[MW-1];
        r_s_bi <= i_b_imag[MW-1];
    end

    // Multiply magnitudes; conjugate B by flipping the sign of a_real*b_imag
    always_ff @(posedge i_clk) begin
        r_p_arbr <= PW'(r_m_ar) * PW'(r_m_br);
        r_p_aibi <= PW'(r_m_ai) * PW'(r_m_bi);
        r_p_aibr <= PW'(r_m_ai) * PW'(r_m_br);
        r_p_arbi <= PW'(r_m_ar) * PW'(r_m_bi);
        r_n_arbr <= r_s_ar ^ r_s_br;
        r_n_aibi <= r_s_ai ^ r_s_bi;
        r_n_aibr <= r_s_ai ^ r_s_br;
        r_n_arbi <= !(r_s_ar ^ r_s_bi);
    end

    // Sign-magnitude add of the product terms
    always_comb begin
        priority if (r_n_arbr == r_n_aibi) begin
            n_tr  = SW'(r_p_arbr) + SW'(r_p_aibi);
            n_ntr = r_n_arbr;
        end else if (r_p_arbr >= r_p_aibi) begin
            n_tr  = SW'(r_p_arbr - r_p_aibi);
            n_ntr = r_n_arbr;
        end else begin
            n_tr  = SW'(r_p_aibi - r_p_arbr);
            n_ntr = r_n_aibi;
        end
        priority if (r_n_aibr == r_n_arbi) begin
            n_ti  = SW'(r_p_aibr) + SW'(r_p_arbi);
            n_nti = r_n_aibr;
        end else if (r_p_aibr >= r_p_arbi) begin
            n_ti  = SW'(r_p_aibr - r_p_arbi);
            n_nti = r_n_aibr;
        end else begin
            n_ti  = SW'(r_p_arbi - r_p_aibr);
            n_nti = r_n_arbi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tr3  <= n_tr;
        r_ti3  <= n_ti;
        r_ntr3 <= n_ntr;
        r_nti3 <= n_nti;
    end

    // Find the leading one of the larger part
    assign n_mx = (r_tr3 > r_ti3) ? r_tr3 : r_ti3;

    always_comb begin
        n_lead = '0;
        for (int i = 0; i < SW; i++) begin
            if (n_mx[i]) begin
                n_lead = LW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tr4   <= XW'(r_tr3);
        r_ti4   <= XW'(r_ti3);
        r_lead4 <= n_lead;
        r_ntr4  <= r_ntr3;
        r_nti4  <= r_nti3;
        r_zero4 <= (n_mx == '0);
    end

    // Shift both parts by one amount so the larger lands at NORM_BIT
    always_comb begin
        if (r_lead4 > LW'(NORM_BIT)) begin
            n_xr = r_tr4 >> (r_lead4 - LW'(NORM_BIT));
            n_xi = r_ti4 >> (r_lead4 - LW'(NORM_BIT));
        end else begin
            n_xr = r_tr4 << (LW'(NORM_BIT) - r_lead4);
            n_xi = r_ti4 << (LW'(NORM_BIT) - r_lead4);
        end
    end

    always_ff @(posedge i_clk) begin
        r_xr5   <= n_xr[X_W-1:0];
        r_xi5   <= n_xi[X_W-1:0];
        r_ntr5  <= r_ntr4;
        r_nti5  <= r_nti4;
        r_zero5 <= r_zero4;
    end

    // Square both parts
    always_ff @(posedge i_clk) begin
        r_sqr6  <= SQW'(r_xr5) * SQW'(r_xr5);
        r_sqi6  <= SQW'(r_xi5) * SQW'(r_xi5);
        r_xr6   <= r_xr5;
        r_xi6   <= r_xi5;
        r_ntr6  <= r_ntr5;
        r_nti6  <= r_nti5;
        r_zero6 <= r_zero5;
    end

    // Add the squares
    always_ff @(posedge i_clk) begin
        r_sum7  <= SQ_W'(r_sqr6) + SQ_W'(r_sqi6);
        r_xr7   <= r_xr6;
        r_xi7   <= r_xi6;
        r_ntr7  <= r_ntr6;
        r_nti7  <= r_nti6;
        r_zero7 <= r_zero6;
    end

    // Advance valid through the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], accept};
        end
    end

    ncps_isqrt #(
        .SIDE_W (SIDE_SQRT)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[6]),
        .i_sq    (r_sum7),
        .i_side  ({r_xr7, r_xi7, r_ntr7, r_nti7, r_zero7}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign sq_xr = sq_side[SIDE_SQRT-1 -: X_W];
    assign sq_xi = sq_side[SIDE_SQRT-1-X_W -: X_W];

    // Form x * Q15_ONE + floor(M / 2) for both parts
    always_ff @(posedge i_clk) begin
        r_num_re <= (NUM_W'(sq_xr) << FRAC_W) - NUM_W'(sq_xr) + NUM_W'(sq_root >> 1);
        r_num_im <= (NUM_W'(sq_xi) << FRAC_W) - NUM_W'(sq_xi) + NUM_W'(sq_root >> 1);
        r_den    <= sq_root;
        r_side8  <= sq_side[SIDE_DIV-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_num <= 1'b0;
        end else begin
            r_vld_num <= sq_valid;
        end
    end

    ncps_qdiv #(
        .SIDE_W (SIDE_DIV)
    ) u_qdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld_num),
        .i_num_re (r_num_re),
        .i_num_im (r_num_im),
        .i_den    (r_den),
        .i_side   (r_side8),
        .o_valid  (dv_valid),
        .o_q_re   (dv_q_re),
        .o_q_im   (dv_q_im),
        .o_side   (dv_side)
    );

    // Saturate at one, then apply signs and force zero on a zero product
    assign sat_re = (dv_q_re > Q15_ONE) ? Q15_ONE : dv_q_re;
    assign sat_im = (dv_q_im > Q15_ONE) ? Q15_ONE : dv_q_im;

    always_ff @(posedge i_clk) begin
        if (dv_side[0]) begin
            r_out_re <= '0;
            r_out_im <= '0;
        end else begin
            r_out_re <= dv_side[2] ? (OUT_W'(0) - sat_re) : sat_re;
            r_out_im <= dv_side[1] ? (OUT_W'(0) - sat_im) : sat_im;
        end
        r_out_zero <= dv_side[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dv_valid;
        end
    end

    assign o_norm_real      = r_out_re;
    assign o_norm_imag      = r_out_im;
    assign o_zero_magnitude = r_out_zero;

endmodule
